// ===== hw/rtl/ipmbd_pkg.sv =====
// Shared types and constants of the IPMB frame decoder.
package ipmbd_pkg;

	// Default frame length limit; bytes beyond it flag an overflow.
	localparam int MAX_FRAME_BYTES_DEF = 32;

	// Header bytes kept per frame (bytes 0 to 5).
	localparam int HDR_LEN = 6;

	// Entries in the queue memory between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Payload counter saturates at its top value.
	localparam logic [4:0] CNT_SAT = 5'd31;

	// Summary status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_HDR_BAD  = 3'd2;
	localparam logic [2:0] ST_FRM_BAD  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] dest_addr;
		logic [5:0] net_function;
		logic [1:0] dest_lun;
		logic [7:0] source_addr;
		logic [1:0] src_lun;
		logic [5:0] seq_number;
		logic [7:0] command;
		logic [7:0] completion_code;
		logic [4:0] payload_count;
	} summary_t;

	// One queue entry: at most one payload result and one summary.
	typedef struct packed {
		logic       pay_vld;
		logic [7:0] pay_byte;
		logic       sum_vld;
		summary_t   sum;
	} q_entry_t;

endpackage

// ===== hw/rtl/ipmbd_front.sv =====
// Front end: per-byte frame tracking, header split and result classification.
module ipmbd_front #(
	parameter int MAX_FRAME_BYTES = ipmbd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          frame_byte,
	input  logic                last_byte,
	input  logic                q_full,
	output logic                q_push,
	output ipmbd_pkg::q_entry_t q_entry
);
	import ipmbd_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_BYTES);

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       hsum_q;
	logic [7:0]       fsum_q;
	logic [7:0]       held_q;
	logic             held_vld_q;
	logic [7:0]       hdr_q [HDR_LEN];
	logic             ovf_q;
	logic [7:0]       cc_q;
	logic [4:0]       cnt_q;

	logic [7:0] hdr_n [HDR_LEN];
	logic [7:0] hsum_n;
	logic [7:0] fsum_n;
	logic       accept;
	logic       ovf_hit;
	logic       resp_n;
	logic       resp_s;
	logic       pay_en;
	logic       cc_en;
	logic       emit_pay;
	logic [4:0] cnt_n;
	logic       short_frm;
	logic [2:0] status;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		for (int k = 0; k < HDR_LEN; k++) begin
			hdr_n[k] = (idx_q == IDX_W'(k)) ? frame_byte : hdr_q[k];
		end
	end

	assign fsum_n   = fsum_q + frame_byte;
	assign hsum_n   = (idx_q < IDX_W'(3)) ? hsum_q + frame_byte : hsum_q;
	assign ovf_hit  = idx_q >= IDX_MAX;
	assign resp_n   = hdr_n[1][2];
	// Responses carry the completion code at byte 6; payload starts one later.
	assign pay_en   = !ovf_hit && (idx_q >= IDX_W'(HDR_LEN))
			&& !(resp_n && idx_q == IDX_W'(HDR_LEN));
	assign cc_en    = !ovf_hit && resp_n && (idx_q == IDX_W'(HDR_LEN)) && !last_byte;
	assign emit_pay = pay_en && held_vld_q;
	assign cnt_n    = (emit_pay && cnt_q != CNT_SAT) ? cnt_q + 5'd1 : cnt_q;

	// A frame of a single byte counts as a request.
	assign resp_s    = (idx_q != '0) && resp_n;
	assign short_frm = (idx_q < IDX_W'(6)) || (resp_s && idx_q < IDX_W'(7));

	always_comb begin
		if (ovf_q || ovf_hit) begin
			status = ST_OVERFLOW;
		end else if (short_frm) begin
			status = ST_SHORT;
		end else if (hsum_n != 8'd0) begin
			status = ST_HDR_BAD;
		end else if (fsum_n != 8'd0) begin
			status = ST_FRM_BAD;
		end else begin
			status = ST_OK;
		end
	end

	assign q_push = accept && (emit_pay || last_byte);

	always_comb begin
		q_entry.pay_vld             = emit_pay;
		q_entry.pay_byte            = held_q;
		q_entry.sum_vld             = last_byte;
		q_entry.sum.status          = status;
		q_entry.sum.dest_addr       = hdr_n[0];
		q_entry.sum.net_function    = hdr_n[1][7:2];
		q_entry.sum.dest_lun        = hdr_n[1][1:0];
		q_entry.sum.source_addr     = hdr_n[3];
		q_entry.sum.src_lun         = hdr_n[4][1:0];
		q_entry.sum.seq_number      = hdr_n[4][7:2];
		q_entry.sum.command         = hdr_n[5];
		q_entry.sum.completion_code = resp_s ? cc_q : 8'd0;
		q_entry.sum.payload_count   = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			hsum_q     <= '0;
			fsum_q     <= '0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
			ovf_q      <= 1'b0;
			cc_q       <= '0;
			cnt_q      <= '0;
			for (int k = 0; k < HDR_LEN; k++) begin
				hdr_q[k] <= '0;
			end
		end else if (accept) begin
			if (last_byte) begin
				idx_q      <= '0;
				hsum_q     <= '0;
				fsum_q     <= '0;
				held_q     <= '0;
				held_vld_q <= 1'b0;
				ovf_q      <= 1'b0;
				cc_q       <= '0;
				cnt_q      <= '0;
				for (int k = 0; k < HDR_LEN; k++) begin
					hdr_q[k] <= '0;
				end
			end else begin
				if (idx_q != IDX_MAX) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				hsum_q <= hsum_n;
				fsum_q <= fsum_n;
				cnt_q  <= cnt_n;
				for (int k = 0; k < HDR_LEN; k++) begin
					hdr_q[k] <= hdr_n[k];
				end
				if (ovf_hit) begin
					ovf_q      <= 1'b1;
					held_vld_q <= 1'b0;
				end else if (pay_en) begin
					held_q     <= frame_byte;
					held_vld_q <= 1'b1;
				end
				if (cc_en) begin
					cc_q <= frame_byte;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ipmbd_fifo.sv =====
// Short queue of classified entries between the front and the back.
module ipmbd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ipmbd_pkg::q_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output ipmbd_pkg::q_entry_t rd_entry
);
	import ipmbd_pkg::*;

	q_entry_t          mem_q [FIFO_DEPTH];
	q_entry_t          head_q;
	logic              head_vld_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              fill;
	logic              mem_rd;
	logic              mem_wr;

	assign full     = cnt_q == FCNT_W'(FIFO_DEPTH);
	assign empty    = !head_vld_q;
	assign rd_entry = head_q;

	// The head register refills when it is free or its entry leaves now.
	assign fill   = !head_vld_q || pop;
	assign mem_rd = fill && (cnt_q != '0);
	// An entry that finds the memory empty and the head free goes straight to the head.
	assign mem_wr = push && !(fill && cnt_q == '0);

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
		if (mem_rd) begin
			head_q <= mem_q[rd_ptr_q];
		end else if (fill && push) begin
			head_q <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
		end else begin
			if (fill) begin
				head_vld_q <= mem_rd || push;
			end
			if (mem_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (mem_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (mem_wr && !mem_rd) begin
				cnt_q <= cnt_q + FCNT_W'(1);
			end else if (mem_rd && !mem_wr) begin
				cnt_q <= cnt_q - FCNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/ipmbd_back.sv =====
// Back end: unpacks queue entries into payload and summary results.
module ipmbd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  ipmbd_pkg::q_entry_t q_entry,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          data_byte,
	output logic                frame_end,
	output ipmbd_pkg::summary_t sum
);
	import ipmbd_pkg::*;

	q_entry_t ent_q;
	logic     pay_pend_q;
	logic     sum_pend_q;
	logic     out_acc;
	logic     load;

	assign out_valid = pay_pend_q || sum_pend_q;
	assign out_acc   = out_valid && out_ready;
	// Take a new entry when nothing is pending or its final result leaves now.
	assign load      = !out_valid || (out_acc && !(pay_pend_q && sum_pend_q));
	assign q_pop     = load && !q_empty;

	assign data_byte = pay_pend_q ? ent_q.pay_byte : 8'd0;
	assign frame_end = !pay_pend_q;
	assign sum       = pay_pend_q ? '0 : ent_q.sum;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_pend_q <= 1'b0;
			sum_pend_q <= 1'b0;
		end else if (load) begin
			pay_pend_q <= q_pop && q_entry.pay_vld;
			sum_pend_q <= q_pop && q_entry.sum_vld;
		end else if (out_acc) begin
			pay_pend_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/ipmb_frame_decoder.sv =====
// Top level of the IPMB frame decoder: front end, entry queue and back end.
// The results of an accepted byte pass through the queue head and the back end entry register.
// Throughput: one byte per cycle unless the queue is full; a last byte that also releases a
// payload byte gives two results, which the back end sends in turn while the queue absorbs input.
// Reset: arst_n clears all frame state and the queue at once; the block then waits
// for byte 0 of a new frame. No clearing pass is needed.
module ipmb_frame_decoder #(
	parameter int MAX_FRAME_BYTES = ipmbd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] frame_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       frame_end,
	output logic [2:0] status,
	output logic [7:0] dest_addr,
	output logic [5:0] net_function,
	output logic [1:0] dest_lun,
	output logic [7:0] source_addr,
	output logic [1:0] src_lun,
	output logic [5:0] seq_number,
	output logic [7:0] command,
	output logic [7:0] completion_code,
	output logic [4:0] payload_count
);
	import ipmbd_pkg::*;

	// Front to queue: one entry per input transfer that yields any result.
	q_entry_t push_entry;
	logic     push;
	logic     full;

	// Queue to back.
	q_entry_t pop_entry;
	logic     pop;
	logic     empty;

	summary_t sum;

	// The front end tracks the byte position, the two running sums and the
	// header bytes. Payload bytes are held back by one transfer so that the
	// checksum byte, always the last, is never sent as payload.
	ipmbd_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_byte(frame_byte),
		.last_byte (last_byte),
		.q_full    (full),
		.q_push    (push),
		.q_entry   (push_entry)
	);

	// The queue lets the front keep taking bytes while the consumer stalls, until it is full.
	ipmbd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(push_entry),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.rd_entry(pop_entry)
	);

	// The back end sends a payload result before the summary of the same entry.
	ipmbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_entry  (pop_entry),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.frame_end(frame_end),
		.sum      (sum)
	);

	// Summary fields read zero on a payload result.
	assign status          = sum.status;
	assign dest_addr       = sum.dest_addr;
	assign net_function    = sum.net_function;
	assign dest_lun        = sum.dest_lun;
	assign source_addr     = sum.source_addr;
	assign src_lun         = sum.src_lun;
	assign seq_number      = sum.seq_number;
	assign command         = sum.command;
	assign completion_code = sum.completion_code;
	assign payload_count   = sum.payload_count;

endmodule
